[design/text_encoding_and_art_sniffer_core_defines.svh]
// Assertion helpers shared by the sniffer core.
`ifndef TEXT_ENCODING_AND_ART_SNIFFER_CORE_DEFINES_SVH
`define TEXT_ENCODING_AND_ART_SNIFFER_CORE_DEFINES_SVH

// Condition implies a property in the same cycle.
`define TES_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Condition implies a property in the following cycle.
`define TES_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[design/tes_pkg.sv]
package tes_pkg;

   // Sizing of the sampled window and of the glyph counters.
   localparam int SAMPLE_LIMIT = 4096;
   localparam int COUNTER_BITS = 32;
   localparam int LANE_W       = $clog2(SAMPLE_LIMIT + 1);
   localparam int CNT_W        = COUNTER_BITS;
   // A sum of up to three lane counts times one hundred.
   localparam int PCT_W        = LANE_W + 9;

   // Byte-order marks as they appear in the head word, first byte lowest.
   localparam logic [31:0] BOM_UTF32BE = 32'hfffe0000;
   localparam logic [31:0] BOM_UTF32LE = 32'h0000feff;
   localparam logic [15:0] BOM_UTF16LE = 16'hfeff;
   localparam logic [15:0] BOM_UTF16BE = 16'hfffe;
   localparam logic [23:0] BOM_UTF8    = 24'hbfbbef;

   typedef enum logic [2:0] {
      ENC_UTF32BE = 3'd0,
      ENC_UTF32LE = 3'd1,
      ENC_UTF16LE = 3'd2,
      ENC_UTF16BE = 3'd3,
      ENC_UTF8    = 3'd4,
      ENC_CP437   = 3'd5,
      ENC_LATIN1  = 3'd6,
      ENC_CP1252  = 3'd7
   } enc_type;

   typedef enum logic [1:0] {
      ART_PLAIN = 2'd0,
      ART_PC    = 2'd1,
      ART_AMIGA = 2'd2
   } art_type;

   // One input item as held in the input register.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_mark;
      logic       no_byte;
   } item_type;

   // Everything the decision needs about a finished buffer.
   typedef struct packed {
      logic [LANE_W-1:0]           count;
      logic [31:0]                 head;
      logic [3:0][LANE_W-1:0]      lane_zeros;
      logic [CNT_W-1:0]            block_count;
      logic [CNT_W-1:0]            topaz_count;
      logic [CNT_W-1:0]            vertical_count;
      logic [CNT_W-1:0]            corner_count;
      logic                        pair_ge2;
      logic                        line_seen;
      logic                        utf8_ok;
   } snap_type;

endpackage

[design/tes_track.sv]
module tes_track (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  tes_pkg::item_type item,
   input  logic              snap_take,
   output logic              snap_valid,
   output tes_pkg::snap_type snap
);
   import tes_pkg::*;

   // Per-buffer state.
   logic [LANE_W-1:0]      count_ff, count_in;
   logic [31:0]            head_ff, head_in;
   logic [3:0][LANE_W-1:0] lanes_ff, lanes_in;
   logic [CNT_W-1:0]       block_ff, block_in;
   logic [CNT_W-1:0]       pair_ff, pair_in;
   logic [CNT_W-1:0]       topaz_ff, topaz_in;
   logic [CNT_W-1:0]       line_ff, line_in;
   logic [CNT_W-1:0]       vert_ff, vert_in;
   logic [CNT_W-1:0]       corner_ff, corner_in;
   logic                   run_odd_ff, run_odd_in;
   logic [1:0]             line_run_ff, line_run_in;
   logic [1:0]             pending_ff, pending_in;
   logic [7:0]             lo_ff, lo_in;
   logic [7:0]             hi_ff, hi_in;
   logic                   failed_ff, failed_in;

   logic                   snap_valid_ff;
   snap_type               snap_ff, snap_in;
   logic [7:0]             b;
   logic                   last_item;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      sat_inc = (&c) ? c : c + CNT_W'(1);
   endfunction

   function automatic logic is_block(input logic [7:0] v);
      is_block = (v >= 8'hb0 && v <= 8'hb2) || (v >= 8'hdb && v <= 8'hdf);
   endfunction

   function automatic logic is_topaz(input logic [7:0] v);
      is_topaz = v == 8'haf || v == 8'ha6 || v == 8'hac || v == 8'hd8 || v == 8'hc6;
   endfunction

   function automatic logic is_corner(input logic [7:0] v);
      is_corner = v == 8'hda || v == 8'hbf || v == 8'hc0 || v == 8'hd9
               || v == 8'hc9 || v == 8'hbb || v == 8'hc8 || v == 8'hbc;
   endfunction

   assign b         = item.data_byte;
   assign last_item = item_valid && item.end_mark;

   // Next state for one byte.
   always_comb begin
      count_in    = count_ff;
      head_in     = head_ff;
      lanes_in    = lanes_ff;
      block_in    = block_ff;
      pair_in     = pair_ff;
      topaz_in    = topaz_ff;
      line_in     = line_ff;
      vert_in     = vert_ff;
      corner_in   = corner_ff;
      run_odd_in  = run_odd_ff;
      line_run_in = line_run_ff;
      pending_in  = pending_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      failed_in   = failed_ff;
      if (!item.no_byte) begin
         // Head bytes, zero lanes and the saturating byte count.
         if (count_ff < LANE_W'(4)) begin
            head_in = head_ff | (32'(b) << {count_ff[1:0], 3'b000});
         end
         if (count_ff < LANE_W'(SAMPLE_LIMIT)) begin
            count_in = count_ff + LANE_W'(1);
            if (b == 8'h00) begin
               lanes_in[count_ff[1:0]] = lanes_ff[count_ff[1:0]] + LANE_W'(1);
            end
         end

         // Block glyphs and pairs of them.
         if (is_block(b)) begin
            block_in = sat_inc(block_ff);
            if (run_odd_ff) begin
               pair_in = sat_inc(pair_ff);
            end
            run_odd_in = !run_odd_ff;
         end else begin
            run_odd_in = 1'b0;
         end

         if (is_topaz(b)) begin
            topaz_in = sat_inc(topaz_ff);
         end

         // A line counts once its run reaches two glyphs.
         if (b == 8'hc4 || b == 8'hcd) begin
            if (line_run_ff < 2'd2) begin
               line_run_in = line_run_ff + 2'd1;
               if (line_run_ff == 2'd1) begin
                  line_in = sat_inc(line_ff);
               end
            end
         end else begin
            line_run_in = 2'd0;
         end

         if (b == 8'hb3 || b == 8'hba) begin
            vert_in = sat_inc(vert_ff);
         end
         if (is_corner(b)) begin
            corner_in = sat_inc(corner_ff);
         end

         // Strict UTF-8 validation; NUL counts as a failure.
         if (pending_ff != 2'd0) begin
            if (b >= lo_ff && b <= hi_ff) begin
               pending_in = pending_ff - 2'd1;
            end else begin
               failed_in  = 1'b1;
               pending_in = 2'd0;
            end
            lo_in = 8'h80;
            hi_in = 8'hbf;
         end else if (b == 8'h00) begin
            failed_in = 1'b1;
         end else if (b[7]) begin
            priority if (b >= 8'hc2 && b <= 8'hdf) begin
               pending_in = 2'd1;
               lo_in = 8'h80;
               hi_in = 8'hbf;
            end else if (b == 8'he0) begin
               pending_in = 2'd2;
               lo_in = 8'ha0;
               hi_in = 8'hbf;
            end else if (b == 8'hed) begin
               pending_in = 2'd2;
               lo_in = 8'h80;
               hi_in = 8'h9f;
            end else if (b >= 8'he1 && b <= 8'hef) begin
               pending_in = 2'd2;
               lo_in = 8'h80;
               hi_in = 8'hbf;
            end else if (b == 8'hf0) begin
               pending_in = 2'd3;
               lo_in = 8'h90;
               hi_in = 8'hbf;
            end else if (b >= 8'hf1 && b <= 8'hf3) begin
               pending_in = 2'd3;
               lo_in = 8'h80;
               hi_in = 8'hbf;
            end else if (b == 8'hf4) begin
               pending_in = 2'd3;
               lo_in = 8'h80;
               hi_in = 8'h8f;
            end else begin
               failed_in = 1'b1;
            end
         end
      end
   end

   // Summary of the buffer including the last byte.
   always_comb begin
      snap_in.count          = count_in;
      snap_in.head           = head_in;
      snap_in.lane_zeros     = lanes_in;
      snap_in.block_count    = block_in;
      snap_in.topaz_count    = topaz_in;
      snap_in.vertical_count = vert_in;
      snap_in.corner_count   = corner_in;
      snap_in.pair_ge2       = pair_in >= CNT_W'(2);
      snap_in.line_seen      = line_in != '0;
      snap_in.utf8_ok        = !failed_in && pending_in == 2'd0;
   end

   // State registers: cleared at reset and after the last item of a buffer.
   always_ff @(posedge clock) begin
      if (reset || last_item) begin
         count_ff    <= '0;
         head_ff     <= '0;
         lanes_ff    <= '0;
         block_ff    <= '0;
         pair_ff     <= '0;
         topaz_ff    <= '0;
         line_ff     <= '0;
         vert_ff     <= '0;
         corner_ff   <= '0;
         run_odd_ff  <= 1'b0;
         line_run_ff <= 2'd0;
         pending_ff  <= 2'd0;
         lo_ff       <= 8'h80;
         hi_ff       <= 8'hbf;
         failed_ff   <= 1'b0;
      end else if (item_valid) begin
         count_ff    <= count_in;
         head_ff     <= head_in;
         lanes_ff    <= lanes_in;
         block_ff    <= block_in;
         pair_ff     <= pair_in;
         topaz_ff    <= topaz_in;
         line_ff     <= line_in;
         vert_ff     <= vert_in;
         corner_ff   <= corner_in;
         run_odd_ff  <= run_odd_in;
         line_run_ff <= line_run_in;
         pending_ff  <= pending_in;
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         failed_ff   <= failed_in;
      end
   end

   // Summary register handed to the decision stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (last_item) begin
         snap_valid_ff <= 1'b1;
      end else if (snap_take) begin
         snap_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (last_item) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

[design/tes_decide.sv]
module tes_decide (
   input  logic              clock,
   input  logic              reset,
   input  logic              art_detect,
   input  logic              snap_valid,
   input  tes_pkg::snap_type snap,
   input  logic              rsp_stall,
   output logic              snap_take,
   output logic              rsp_valid,
   output logic [2:0]        rsp_encoding_code,
   output logic [1:0]        rsp_art_class
);
   import tes_pkg::*;

   logic                rsp_valid_ff;
   logic [2:0]          enc_ff;
   logic [1:0]          art_ff;
   logic                rsp_free;

   logic [CNT_W:0]      topaz2;
   logic [CNT_W+1:0]    glyph_sum;
   logic                art_pc;
   art_type             art;
   enc_type             enc;

   logic [PCT_W-1:0]    s_pct65, s_pct35, s_pct5;
   logic [PCT_W-1:0]    z0_pct, z3_pct, z123_pct, z012_pct, z13_pct, z02_pct;
   logic [LANE_W-1:0]   z0, z1, z2, z3;

   assign z0 = snap.lane_zeros[0];
   assign z1 = snap.lane_zeros[1];
   assign z2 = snap.lane_zeros[2];
   assign z3 = snap.lane_zeros[3];

   // Lane percentages as constant multiplies.
   assign s_pct65  = PCT_W'(snap.count) * PCT_W'(65);
   assign s_pct35  = PCT_W'(snap.count) * PCT_W'(35);
   assign s_pct5   = PCT_W'(snap.count) * PCT_W'(5);
   assign z0_pct   = PCT_W'(z0) * PCT_W'(100);
   assign z3_pct   = PCT_W'(z3) * PCT_W'(100);
   assign z123_pct = (PCT_W'(z1) + PCT_W'(z2) + PCT_W'(z3)) * PCT_W'(100);
   assign z012_pct = (PCT_W'(z0) + PCT_W'(z1) + PCT_W'(z2)) * PCT_W'(100);
   assign z13_pct  = (PCT_W'(z1) + PCT_W'(z3)) * PCT_W'(100);
   assign z02_pct  = (PCT_W'(z0) + PCT_W'(z2)) * PCT_W'(100);

   // Art class from the glyph counts.
   assign topaz2    = {snap.topaz_count, 1'b0};
   assign glyph_sum = (CNT_W+2)'(snap.block_count) + (CNT_W+2)'(snap.vertical_count)
                    + (CNT_W+2)'(snap.corner_count);
   assign art_pc = (snap.block_count >= CNT_W'(6) && snap.pair_ge2
                    && (CNT_W+1)'(snap.block_count) > topaz2)
                || (snap.line_seen && snap.corner_count >= CNT_W'(2)
                    && glyph_sum > (CNT_W+2)'(topaz2));

   always_comb begin
      if (!art_detect) begin
         art = ART_PLAIN;
      end else if (art_pc) begin
         art = ART_PC;
      end else if (snap.topaz_count >= CNT_W'(3)) begin
         art = ART_AMIGA;
      end else begin
         art = ART_PLAIN;
      end
   end

   // Encoding: byte-order marks, then zero lanes, then UTF-8, then art.
   always_comb begin
      priority if (snap.count >= LANE_W'(4) && snap.head == BOM_UTF32BE) begin
         enc = ENC_UTF32BE;
      end else if (snap.count >= LANE_W'(4) && snap.head == BOM_UTF32LE) begin
         enc = ENC_UTF32LE;
      end else if (snap.count >= LANE_W'(2) && snap.head[15:0] == BOM_UTF16LE) begin
         enc = ENC_UTF16LE;
      end else if (snap.count >= LANE_W'(2) && snap.head[15:0] == BOM_UTF16BE) begin
         enc = ENC_UTF16BE;
      end else if (snap.count >= LANE_W'(3) && snap.head[23:0] == BOM_UTF8) begin
         enc = ENC_UTF8;
      end else if (snap.count >= LANE_W'(8) && z123_pct > s_pct65 && z0_pct < s_pct5) begin
         enc = ENC_UTF32LE;
      end else if (snap.count >= LANE_W'(8) && z012_pct > s_pct65 && z3_pct < s_pct5) begin
         enc = ENC_UTF32BE;
      end else if (snap.count >= LANE_W'(4) && z13_pct > s_pct35 && z02_pct < s_pct5) begin
         enc = ENC_UTF16LE;
      end else if (snap.count >= LANE_W'(4) && z02_pct > s_pct35 && z13_pct < s_pct5) begin
         enc = ENC_UTF16BE;
      end else if (snap.utf8_ok) begin
         enc = ENC_UTF8;
      end else if (art == ART_PC) begin
         enc = ENC_CP437;
      end else if (art == ART_AMIGA) begin
         enc = ENC_LATIN1;
      end else begin
         enc = ENC_CP1252;
      end
   end

   // Result register.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign snap_take = snap_valid && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_take) begin
         enc_ff <= enc;
         art_ff <= art;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_encoding_code = enc_ff;
   assign rsp_art_class     = art_ff;

endmodule

[design/text_encoding_and_art_sniffer_core.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_valid, req_stall   req_data_byte, req_end_mark, req_no_byte
// rsp_      out        rsp_valid, rsp_stall   rsp_encoding_code, rsp_art_class
// csr_      in         csr_write_enable       csr_write_data (art detection enable)
//
// One item per cycle is taken while req_stall is low.
// The stages are input register, byte update with summary register, and result register.
// A last item waits while the summary register is full and its result is stalled.
// Synchronous reset clears all buffer state and sets art detection on; no clearing pass.
// Only end_mark items produce a result; items with no byte and no end mark are dropped.
`include "text_encoding_and_art_sniffer_core_defines.svh"

module text_encoding_and_art_sniffer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_mark,
   input  logic       req_no_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_encoding_code,
   output logic [1:0] rsp_art_class,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import tes_pkg::*;

   logic     in_valid_ff;
   item_type in_item_ff;
   logic     blocked;
   logic     proc;
   logic     art_detect_ff;
   logic     snap_valid;
   logic     snap_take;
   snap_type snap;

   // Art detection enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         art_detect_ff <= 1'b1;
      end else if (csr_write_enable) begin
         art_detect_ff <= csr_write_data;
      end
   end

   // A last item holds only while the summary register stays full this cycle.
   assign blocked   = in_valid_ff && in_item_ff.end_mark && snap_valid && !snap_take;
   assign proc      = in_valid_ff && !blocked;
   assign req_stall = blocked;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!blocked) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !blocked) begin
         in_item_ff.data_byte <= req_data_byte;
         in_item_ff.end_mark  <= req_end_mark;
         in_item_ff.no_byte   <= req_no_byte;
      end
   end

   tes_track u_track (
      .clock      (clock),
      .reset      (reset),
      .item_valid (proc),
      .item       (in_item_ff),
      .snap_take  (snap_take),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   tes_decide u_decide (
      .clock             (clock),
      .reset             (reset),
      .art_detect        (art_detect_ff),
      .snap_valid        (snap_valid),
      .snap              (snap),
      .rsp_stall         (rsp_stall),
      .snap_take         (snap_take),
      .rsp_valid         (rsp_valid),
      .rsp_encoding_code (rsp_encoding_code),
      .rsp_art_class     (rsp_art_class)
   );

   // A pending summary is never overwritten by a new last item.
   `TES_ASSERT_NOW(a_snap_kept, snap_valid && !snap_take, !(proc && in_item_ff.end_mark), "summary overwritten")
   // A summary handed on shows up as a result in the next cycle.
   `TES_ASSERT_NEXT(a_take_shows, snap_take, rsp_valid, "taken summary lost")
   // The CP437 fallback agrees with the PC art class.
   `TES_ASSERT_NOW(a_cp437_pc, rsp_valid && rsp_encoding_code == ENC_CP437, rsp_art_class == ART_PC, "CP437 without PC art")

endmodule

[dv/sniff_check_pkg.sv]
package sniff_check_pkg;

   import tes_pkg::*;

   // One expected result: the encoding and the art class of a finished buffer.
   typedef struct packed {
      enc_type enc;
      art_type art;
   } verdict_type;

   // Tracks the buffer that is being streamed in and checks the verdicts that come out.
   class sniff_tracker;
      bit          art_on;
      bit [31:0]   n_bytes;
      bit [31:0]   head;
      longint unsigned zeros [4];
      bit [31:0]   blocks, pairs, topaz, lines, verticals, corners;
      bit          block_odd;
      int unsigned line_len;
      int unsigned u8_left;
      bit [7:0]    u8_lo, u8_hi;
      bit          u8_bad;
      verdict_type verdicts_due [$];
      int unsigned mismatches;

      function new();
         art_on = 1'b1;
         mismatches = 0;
         clear_buffer();
      endfunction

      function void clear_buffer();
         n_bytes = '0;
         head = '0;
         foreach (zeros[i]) zeros[i] = 0;
         blocks = '0;
         pairs = '0;
         topaz = '0;
         lines = '0;
         verticals = '0;
         corners = '0;
         block_odd = 1'b0;
         line_len = 0;
         u8_left = 0;
         u8_lo = 8'h80;
         u8_hi = 8'hbf;
         u8_bad = 1'b0;
      endfunction

      // Glyph counters stop at their maximum.
      function void sat_inc(inout bit [31:0] c);
         if (c != '1) c++;
      endfunction

      // Folds one accepted item into the buffer and, on the last item, queues the verdict.
      function void take_item(bit [7:0] b, bit last, bit none);
         longint unsigned n, s, t2, z0, z1, z2, z3;
         art_type     a;
         enc_type     e;
         verdict_type v;
         if (!none) begin
            // Head word, zero lanes over the sampled window, and the byte count.
            if (n_bytes < 4) head[n_bytes[1:0]*8 +: 8] = b;
            if (n_bytes < SAMPLE_LIMIT && b == 8'h00) zeros[n_bytes[1:0]]++;
            if (n_bytes != '1) n_bytes++;

            // Blocks and pairs of adjacent blocks.
            if ((b >= 8'hb0 && b <= 8'hb2) || (b >= 8'hdb && b <= 8'hdf)) begin
               sat_inc(blocks);
               if (block_odd) sat_inc(pairs);
               block_odd = !block_odd;
            end else begin
               block_odd = 1'b0;
            end
            if (b inside {8'haf, 8'ha6, 8'hac, 8'hd8, 8'hc6}) sat_inc(topaz);

            // A horizontal line counts once when its run reaches two glyphs.
            if (b == 8'hc4 || b == 8'hcd) begin
               if (line_len < 2) begin
                  line_len++;
                  if (line_len == 2) sat_inc(lines);
               end
            end else begin
               line_len = 0;
            end
            if (b == 8'hb3 || b == 8'hba) sat_inc(verticals);
            if (b inside {8'hda, 8'hbf, 8'hc0, 8'hd9, 8'hc9, 8'hbb, 8'hc8, 8'hbc})
               sat_inc(corners);

            // Strict UTF-8: bounded continuations, no NUL, no overlong or surrogate forms.
            if (u8_left != 0) begin
               if (b >= u8_lo && b <= u8_hi) begin
                  u8_left--;
               end else begin
                  u8_bad = 1'b1;
                  u8_left = 0;
               end
               u8_lo = 8'h80;
               u8_hi = 8'hbf;
            end else if (b == 8'h00) begin
               u8_bad = 1'b1;
            end else if (b >= 8'h80) begin
               u8_lo = 8'h80;
               u8_hi = 8'hbf;
               if (b >= 8'hc2 && b <= 8'hdf) begin
                  u8_left = 1;
               end else if (b >= 8'he0 && b <= 8'hef) begin
                  u8_left = 2;
                  if (b == 8'he0) u8_lo = 8'ha0;
                  if (b == 8'hed) u8_hi = 8'h9f;
               end else if (b >= 8'hf0 && b <= 8'hf4) begin
                  u8_left = 3;
                  if (b == 8'hf0) u8_lo = 8'h90;
                  if (b == 8'hf4) u8_hi = 8'h8f;
               end else begin
                  u8_bad = 1'b1;
               end
            end
         end
         if (!last) return;

         // Art class, forced to plain when detection is off.
         a = ART_PLAIN;
         t2 = 2 * longint'(topaz);
         if (art_on) begin
            if ((blocks >= 6 && pairs >= 2 && longint'(blocks) > t2) ||
                (lines > 0 && corners >= 2 &&
                 longint'(blocks) + longint'(verticals) + longint'(corners) > t2))
               a = ART_PC;
            else if (topaz >= 3)
               a = ART_AMIGA;
         end

         // Byte-order marks first, then the zero-lane shares, then UTF-8, then the art class.
         n = n_bytes;
         s = (n < SAMPLE_LIMIT) ? n : SAMPLE_LIMIT;
         z0 = zeros[0];
         z1 = zeros[1];
         z2 = zeros[2];
         z3 = zeros[3];
         if (n >= 4 && head == BOM_UTF32BE) e = ENC_UTF32BE;
         else if (n >= 4 && head == BOM_UTF32LE) e = ENC_UTF32LE;
         else if (n >= 2 && head[15:0] == BOM_UTF16LE) e = ENC_UTF16LE;
         else if (n >= 2 && head[15:0] == BOM_UTF16BE) e = ENC_UTF16BE;
         else if (n >= 3 && head[23:0] == BOM_UTF8) e = ENC_UTF8;
         else if (s >= 8 && (z1 + z2 + z3) * 100 > s * 65 && z0 * 100 < s * 5) e = ENC_UTF32LE;
         else if (s >= 8 && (z0 + z1 + z2) * 100 > s * 65 && z3 * 100 < s * 5) e = ENC_UTF32BE;
         else if (s >= 4 && (z1 + z3) * 100 > s * 35 && (z0 + z2) * 100 < s * 5) e = ENC_UTF16LE;
         else if (s >= 4 && (z0 + z2) * 100 > s * 35 && (z1 + z3) * 100 < s * 5) e = ENC_UTF16BE;
         else if (!u8_bad && u8_left == 0) e = ENC_UTF8;
         else if (a == ART_PC) e = ENC_CP437;
         else if (a == ART_AMIGA) e = ENC_LATIN1;
         else e = ENC_CP1252;

         v.enc = e;
         v.art = a;
         verdicts_due.push_back(v);
         clear_buffer();
      endfunction

      // Compares one accepted result with the oldest verdict still due.
      function void match_verdict(logic [2:0] enc, logic [1:0] art);
         verdict_type want;
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result, encoding_code %0d art_class %0d",
                     $time, enc, art);
            mismatches++;
            return;
         end
         want = verdicts_due.pop_front();
         if (enc !== want.enc) begin
            $display("%0t: encoding_code expected %0d (%s) actual %0d",
                     $time, want.enc, want.enc.name(), enc);
            mismatches++;
         end
         if (art !== want.art) begin
            $display("%0t: art_class expected %0d (%s) actual %0d",
                     $time, want.art, want.art.name(), art);
            mismatches++;
         end
      endfunction
   endclass

endpackage

[dv/text_encoding_and_art_sniffer_core_tb.sv]
module text_encoding_and_art_sniffer_core_tb;

   import tes_pkg::*;
   import sniff_check_pkg::*;

   // Kinds of random buffers.
   typedef enum int {
      SHAPE_TEXT, SHAPE_BROKEN, SHAPE_WIDE16, SHAPE_WIDE32, SHAPE_BLOCKS,
      SHAPE_LINES, SHAPE_TOPAZ, SHAPE_NOISE, SHAPE_TINY, SHAPE_SOUP
   } shape_type;

   // Groups of bytes that the glyph counters look for.
   typedef enum int {
      GLYPH_BLOCK, GLYPH_TOPAZ, GLYPH_LINE, GLYPH_VERT, GLYPH_CORNER, GLYPH_ASCII, GLYPH_SPACE
   } glyph_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_mark = 1'b0;
   logic       req_no_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_encoding_code;
   logic [1:0] rsp_art_class;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data = 1'b0;

   sniff_tracker tracker;
   bit [7:0]     buf_q [$];
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           sent_items = 0;

   text_encoding_and_art_sniffer_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_mark      (req_end_mark),
      .req_no_byte       (req_no_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_encoding_code (rsp_encoding_code),
      .rsp_art_class     (rsp_art_class),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always #2 clock = ~clock;

   // Result side: check what was taken at this edge, then pick the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.match_verdict(rsp_encoding_code, rsp_art_class);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Offers one item, after an optional idle stretch, and waits until it is taken.
   task automatic send_item(input bit [7:0] b, input bit last, input bit none);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_end_mark  <= last;
      req_no_byte   <= none;
      do @(posedge clock); while (req_stall);
      tracker.take_item(b, last, none);
   endtask

   // Streams the buffer in buf_q, with stray empty items and sometimes an empty last item.
   task automatic send_buffer();
      int  k;
      bit  empty_tail;
      empty_tail = (buf_q.size() == 0) || ($urandom_range(9) == 0);
      for (k = 0; k < buf_q.size(); k++) begin
         if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b1);
         send_item(buf_q[k], !empty_tail && k == buf_q.size() - 1, 1'b0);
      end
      if (empty_tail) send_item(8'($urandom), 1'b1, 1'b1);
   endtask

   // Waits until every verdict has arrived and the pipeline has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.verdicts_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_art_detect(input bit v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.art_on = v;
   endtask

   // A continuation byte, often right at one of its bounds.
   function automatic bit [7:0] pick_cont(bit [7:0] lo, bit [7:0] hi);
      case ($urandom_range(3))
         0: return lo;
         1: return hi;
         default: return 8'($urandom_range(hi, lo));
      endcase
   endfunction

   function automatic bit [7:0] pick_glyph(glyph_type g);
      case (g)
         GLYPH_BLOCK: begin
            if ($urandom_range(1)) return 8'($urandom_range(8'hb2, 8'hb0));
            return 8'($urandom_range(8'hdf, 8'hdb));
         end
         GLYPH_TOPAZ: begin
            case ($urandom_range(4))
               0: return 8'haf;
               1: return 8'ha6;
               2: return 8'hac;
               3: return 8'hd8;
               default: return 8'hc6;
            endcase
         end
         GLYPH_LINE: return $urandom_range(1) ? 8'hc4 : 8'hcd;
         GLYPH_VERT: return $urandom_range(1) ? 8'hb3 : 8'hba;
         GLYPH_CORNER: begin
            case ($urandom_range(7))
               0: return 8'hda;
               1: return 8'hbf;
               2: return 8'hc0;
               3: return 8'hd9;
               4: return 8'hc9;
               5: return 8'hbb;
               6: return 8'hc8;
               default: return 8'hbc;
            endcase
         end
         GLYPH_ASCII: return 8'($urandom_range(8'h7e, 8'h21));
         default: return $urandom_range(2) ? 8'h20 : 8'h0a;
      endcase
   endfunction

   // Appends one well-formed UTF-8 character.
   task automatic add_utf8_char();
      bit [7:0] lead;
      case ($urandom_range(5))
         0, 1: buf_q.push_back(8'($urandom_range(8'h7f, 8'h01)));
         2: begin
            buf_q.push_back(pick_cont(8'hc2, 8'hdf));
            buf_q.push_back(pick_cont(8'h80, 8'hbf));
         end
         3: begin
            lead = pick_cont(8'he0, 8'hef);
            if ($urandom_range(2) == 0) lead = 8'hed;
            buf_q.push_back(lead);
            if (lead == 8'he0) buf_q.push_back(pick_cont(8'ha0, 8'hbf));
            else if (lead == 8'hed) buf_q.push_back(pick_cont(8'h80, 8'h9f));
            else buf_q.push_back(pick_cont(8'h80, 8'hbf));
            buf_q.push_back(pick_cont(8'h80, 8'hbf));
         end
         default: begin
            lead = 8'($urandom_range(8'hf4, 8'hf0));
            buf_q.push_back(lead);
            if (lead == 8'hf0) buf_q.push_back(pick_cont(8'h90, 8'hbf));
            else if (lead == 8'hf4) buf_q.push_back(pick_cont(8'h80, 8'h8f));
            else buf_q.push_back(pick_cont(8'h80, 8'hbf));
            buf_q.push_back(pick_cont(8'h80, 8'hbf));
            buf_q.push_back(pick_cont(8'h80, 8'hbf));
         end
      endcase
   endtask

   // Fills buf_q with one buffer of the given kind.
   task automatic build_buffer(input shape_type shape);
      int       k, n, pos;
      bit       le, noisy;
      bit [7:0] c;
      buf_q.delete();
      case (shape)
         SHAPE_TEXT, SHAPE_BROKEN: begin
            if ($urandom_range(5) == 0) begin
               buf_q.push_back(8'hef);
               buf_q.push_back(8'hbb);
               buf_q.push_back(8'hbf);
            end
            n = $urandom_range(12, 1);
            for (k = 0; k < n; k++) add_utf8_char();
            if (shape == SHAPE_BROKEN) begin
               pos = $urandom_range(buf_q.size());
               case ($urandom_range(4))
                  // Truncated multibyte character at the end.
                  0: begin
                     buf_q.push_back(8'($urandom_range(8'hf4, 8'he1)));
                     if ($urandom_range(1)) buf_q.push_back(8'h80);
                  end
                  1: buf_q.insert(pos, 8'h00);
                  // Lead bytes that can never start a character.
                  2: begin
                     if ($urandom_range(1)) buf_q.insert(pos, 8'($urandom_range(8'hc1, 8'h80)));
                     else buf_q.insert(pos, 8'($urandom_range(8'hff, 8'hf5)));
                  end
                  // Second byte outside the narrowed bounds.
                  3: begin
                     case ($urandom_range(3))
                        0: begin buf_q.push_back(8'he0); buf_q.push_back(pick_cont(8'h80, 8'h9f)); end
                        1: begin buf_q.push_back(8'hed); buf_q.push_back(pick_cont(8'ha0, 8'hbf)); end
                        2: begin buf_q.push_back(8'hf0); buf_q.push_back(pick_cont(8'h80, 8'h8f)); end
                        default: begin
                           buf_q.push_back(8'hf4);
                           buf_q.push_back(pick_cont(8'h90, 8'hbf));
                        end
                     endcase
                     buf_q.push_back(8'h80);
                     buf_q.push_back(8'h80);
                  end
                  default: if (buf_q.size() > 0) buf_q[$urandom_range(buf_q.size() - 1)] = 8'($urandom);
               endcase
            end
         end
         SHAPE_WIDE16: begin
            le = $urandom_range(1);
            noisy = ($urandom_range(3) == 0);
            if ($urandom_range(2) == 0) begin
               buf_q.push_back(le ? 8'hff : 8'hfe);
               buf_q.push_back(le ? 8'hfe : 8'hff);
            end
            n = $urandom_range(24, 2);
            for (k = 0; k < n; k++) begin
               c = pick_glyph(GLYPH_ASCII);
               if (noisy && $urandom_range(4) == 0) begin
                  buf_q.push_back(8'($urandom));
                  buf_q.push_back(8'($urandom));
               end else begin
                  buf_q.push_back(le ? c : 8'h00);
                  buf_q.push_back(le ? 8'h00 : c);
               end
            end
         end
         SHAPE_WIDE32: begin
            le = $urandom_range(1);
            noisy = ($urandom_range(3) == 0);
            if ($urandom_range(2) == 0) begin
               if (le) begin
                  buf_q.push_back(8'hff); buf_q.push_back(8'hfe);
                  buf_q.push_back(8'h00); buf_q.push_back(8'h00);
               end else begin
                  buf_q.push_back(8'h00); buf_q.push_back(8'h00);
                  buf_q.push_back(8'hfe); buf_q.push_back(8'hff);
               end
            end
            n = $urandom_range(10, 2);
            for (k = 0; k < n; k++) begin
               c = pick_glyph(GLYPH_ASCII);
               if (noisy && $urandom_range(3) == 0) c = 8'($urandom);
               if (!le) begin buf_q.push_back(8'h00); buf_q.push_back(8'h00); buf_q.push_back(8'h00); end
               buf_q.push_back(c);
               if (le) begin buf_q.push_back(8'h00); buf_q.push_back(8'h00); buf_q.push_back(8'h00); end
            end
         end
         SHAPE_BLOCKS: begin
            n = $urandom_range(40, 6);
            for (k = 0; k < n; k++) begin
               case ($urandom_range(9))
                  0, 1, 2, 3, 4: buf_q.push_back(pick_glyph(GLYPH_BLOCK));
                  5, 6, 7: buf_q.push_back(pick_glyph(GLYPH_SPACE));
                  8: buf_q.push_back(pick_glyph(GLYPH_ASCII));
                  default: buf_q.push_back(pick_glyph(GLYPH_TOPAZ));
               endcase
            end
         end
         SHAPE_LINES: begin
            n = $urandom_range(40, 4);
            for (k = 0; k < n; k++) begin
               case ($urandom_range(19))
                  0, 1, 2, 3, 4, 5, 6: buf_q.push_back(pick_glyph(GLYPH_LINE));
                  7, 8, 9, 10: buf_q.push_back(pick_glyph(GLYPH_CORNER));
                  11, 12, 13: buf_q.push_back(pick_glyph(GLYPH_VERT));
                  14, 15: buf_q.push_back(pick_glyph(GLYPH_ASCII));
                  16, 17: buf_q.push_back(pick_glyph(GLYPH_SPACE));
                  18: buf_q.push_back(pick_glyph(GLYPH_BLOCK));
                  default: buf_q.push_back(pick_glyph(GLYPH_TOPAZ));
               endcase
            end
         end
         SHAPE_TOPAZ: begin
            n = $urandom_range(30, 3);
            for (k = 0; k < n; k++) begin
               case ($urandom_range(9))
                  0, 1, 2: buf_q.push_back(pick_glyph(GLYPH_TOPAZ));
                  3: buf_q.push_back(pick_glyph(GLYPH_BLOCK));
                  4: buf_q.push_back(pick_glyph(GLYPH_SPACE));
                  default: buf_q.push_back(pick_glyph(GLYPH_ASCII));
               endcase
            end
         end
         SHAPE_NOISE: begin
            n = $urandom_range(30, 1);
            for (k = 0; k < n; k++) buf_q.push_back(8'($urandom));
         end
         SHAPE_TINY: begin
            // Short buffers near the byte-order-mark and sample-size thresholds.
            n = $urandom_range(7, 1);
            for (k = 0; k < n; k++) begin
               case ($urandom_range(7))
                  0, 1: buf_q.push_back(8'h00);
                  2: buf_q.push_back(8'hff);
                  3: buf_q.push_back(8'hfe);
                  4: buf_q.push_back(8'hef);
                  5: buf_q.push_back(8'hbb);
                  6: buf_q.push_back(8'hbf);
                  default: buf_q.push_back(8'($urandom));
               endcase
            end
         end
         default: begin
            n = $urandom_range(40, 1);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(7) == 0) buf_q.push_back(8'h00);
               else buf_q.push_back(pick_glyph(glyph_type'($urandom_range(GLYPH_SPACE))));
            end
         end
      endcase
   endtask

   // Run limit.
   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int        chunk;
      shape_type shape;
      tracker = new();
      send_idle_pct  = 36;
      recv_stall_pct = 71;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_art_detect(1'b1);

      // Directed buffers: empty, stray empty item, each mark, empty last item, cut UTF-8.
      send_item(8'h5a, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hfe, 1'b0, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'hfe, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'hfe, 1'b0, 1'b0);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'hfe, 1'b0, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'hef, 1'b0, 1'b0);
      send_item(8'hbb, 1'b0, 1'b0);
      send_item(8'hbf, 1'b1, 1'b0);
      send_item(8'he2, 1'b0, 1'b0);
      send_item(8'h82, 1'b1, 1'b0);

      // Random buffers in six stretches, two per idling mix, with art detection alternating.
      for (chunk = 0; chunk < 6; chunk++) begin
         settle();
         write_art_detect(chunk[0]);
         if (chunk == 2) begin
            send_idle_pct  = 71;
            recv_stall_pct = 36;
         end else if (chunk == 4) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         while (sent_items < (chunk + 1) * 210) begin
            case ($urandom_range(19))
               0, 1, 2: shape = SHAPE_TEXT;
               3, 4: shape = SHAPE_BROKEN;
               5, 6: shape = SHAPE_WIDE16;
               7, 8: shape = SHAPE_WIDE32;
               9, 10, 11: shape = SHAPE_BLOCKS;
               12, 13: shape = SHAPE_LINES;
               14, 15: shape = SHAPE_TOPAZ;
               16: shape = SHAPE_NOISE;
               17, 18: shape = SHAPE_TINY;
               default: shape = SHAPE_SOUP;
            endcase
            build_buffer(shape);
            sent_items += buf_q.size() + 1;
            send_buffer();
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.verdicts_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
